// ===== rtl/core/fuel_sensor_frame_receiver_defines.svh =====
// ---------------------------------------------------------------------------
// Fuel sensor frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clock, quiet under reset.
// ---------------------------------------------------------------------------
`ifndef FUEL_SENSOR_FRAME_RECEIVER_DEFINES_SVH
`define FUEL_SENSOR_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication
`define FSFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fsfr_pkg.sv =====
// ---------------------------------------------------------------------------
// Fuel sensor frame receiver package
// Frame constants, status codes, CRC-8 (reflected 0x8C) fold and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsfr_pkg;

   localparam logic [3:0] FRAME_LENGTH = 4'd9;
   localparam logic [3:0] COUNT_MAX    = 4'd15;
   localparam logic [3:0] POS_START    = 4'd0;
   localparam logic [3:0] POS_ADDRESS  = 4'd1;
   localparam logic [3:0] POS_FORMAT   = 4'd2;
   localparam logic [3:0] POS_LEVEL_LO = 4'd4;
   localparam logic [3:0] POS_LEVEL_HI = 4'd5;
   localparam logic [3:0] POS_CRC_END  = 4'd8;

   localparam logic [7:0] START_BYTE  = 8'h3E;
   localparam logic [7:0] FORMAT_BYTE = 8'h06;

   localparam logic [7:0] FIRST_ADDRESS_RESET  = 8'd75;
   localparam logic [7:0] SECOND_ADDRESS_RESET = 8'd76;

   localparam logic [7:0] CRC_TERMS [8] = '{
      8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
   };

   typedef enum logic [1:0] {
      CSR_FIRST_ADDRESS  = 2'd0,
      CSR_SECOND_ADDRESS = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_LENGTH  = 3'd1,
      STATUS_BAD_HEADER  = 3'd2,
      STATUS_BAD_CRC     = 3'd3,
      STATUS_BAD_ADDRESS = 3'd4
   } status_type;

   typedef struct packed {
      logic [3:0]  length;
      logic        header_good;
      logic [7:0]  crc_calc;
      logic [7:0]  crc_rx;
      logic [7:0]  address;
      logic [15:0] level;
   } summary_type;

   typedef struct packed {
      status_type  status;
      logic        sensor_index;
      logic [15:0] level;
   } verdict_type;

   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] r;
      x = crc ^ b;
      r = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (x[k]) begin
            r = r ^ CRC_TERMS[k];
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/fsfr_tracker.sv =====
// ---------------------------------------------------------------------------
// Fuel sensor frame tracker
// Byte count, running CRC and field captures for the packet in progress.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsfr_tracker import fsfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  rx_byte,
   input  logic        end_of_packet,
   output summary_type summary
);

   logic [3:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic       header_ff, header_in;
   logic [7:0] address_ff, address_in;
   logic [7:0] level_lo_ff, level_lo_in;
   logic [7:0] level_hi_ff, level_hi_in;
   logic [7:0] crc_rx_ff, crc_rx_in;

   always_comb begin
      crc_in      = (pos_ff < POS_CRC_END) ? crc_fold(crc_ff, rx_byte) : crc_ff;
      header_in   = header_ff;
      address_in  = address_ff;
      level_lo_in = level_lo_ff;
      level_hi_in = level_hi_ff;
      crc_rx_in   = crc_rx_ff;
      case (pos_ff)
         POS_START:    header_in   = (rx_byte == START_BYTE);
         POS_ADDRESS:  address_in  = rx_byte;
         POS_FORMAT:   header_in   = header_ff && (rx_byte == FORMAT_BYTE);
         POS_LEVEL_LO: level_lo_in = rx_byte;
         POS_LEVEL_HI: level_hi_in = rx_byte;
         POS_CRC_END:  crc_rx_in   = rx_byte;
         default:      ;
      endcase
      pos_in = (pos_ff < COUNT_MAX) ? pos_ff + 4'd1 : pos_ff;
   end

   assign summary = '{
      length:      pos_in,
      header_good: header_in,
      crc_calc:    crc_in,
      crc_rx:      crc_rx_in,
      address:     address_in,
      level:       {level_hi_in, level_lo_in}
   };

   always_ff @(posedge clock) begin
      if (reset || (take && end_of_packet)) begin
         pos_ff      <= '0;
         crc_ff      <= '0;
         header_ff   <= 1'b0;
         address_ff  <= '0;
         level_lo_ff <= '0;
         level_hi_ff <= '0;
         crc_rx_ff   <= '0;
      end else if (take) begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         header_ff   <= header_in;
         address_ff  <= address_in;
         level_lo_ff <= level_lo_in;
         level_hi_ff <= level_hi_in;
         crc_rx_ff   <= crc_rx_in;
      end
   end

endmodule

// ===== rtl/core/fsfr_verdict.sv =====
// ---------------------------------------------------------------------------
// Fuel sensor frame verdict
// Ordered checks: length, header, CRC, address; first failure sets status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsfr_verdict import fsfr_pkg::*; (
   input  summary_type summary,
   input  logic [7:0]  first_address,
   input  logic [7:0]  second_address,
   output verdict_type verdict
);

   always_comb begin
      verdict.status       = STATUS_OK;
      verdict.sensor_index = 1'b0;
      verdict.level        = 16'd0;
      if (summary.length != FRAME_LENGTH) begin
         verdict.status = STATUS_BAD_LENGTH;
      end else if (!summary.header_good) begin
         verdict.status = STATUS_BAD_HEADER;
      end else if (summary.crc_rx != summary.crc_calc) begin
         verdict.status = STATUS_BAD_CRC;
      end else if (summary.address == first_address) begin
         verdict.level = summary.level;
      end else if (summary.address == second_address) begin
         verdict.sensor_index = 1'b1;
         verdict.level        = summary.level;
      end else begin
         verdict.status = STATUS_BAD_ADDRESS;
      end
   end

endmodule

// ===== rtl/core/fuel_sensor_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// Fuel sensor frame receiver
// Checks 9-byte fuel level sensor packets and reports status and level.
// ---------------------------------------------------------------------------
// Result: registered, valid in the cycle after the request carrying the last byte.
// Throughput: 1 byte per cycle; ready drops only while a result is stalled.
// Reset: clears the packet in progress and any pending result, and loads
// the sensor addresses with 75 and 76.
`timescale 1ns / 1ps
`include "fuel_sensor_frame_receiver_defines.svh"

module fuel_sensor_frame_receiver import fsfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_packet,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_frame_status,
   output logic        rsp_sensor_index,
   output logic [15:0] rsp_fuel_level_tenths,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic        take;
   summary_type summary;
   verdict_type verdict;
   logic [7:0]  first_address_ff;
   logic [7:0]  second_address_ff;
   logic        rsp_valid_ff;
   verdict_type rsp_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_address_ff  <= FIRST_ADDRESS_RESET;
         second_address_ff <= SECOND_ADDRESS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FIRST_ADDRESS:  first_address_ff  <= csr_data;
            CSR_SECOND_ADDRESS: second_address_ff <= csr_data;
            default:            ;
         endcase
      end
   end

   fsfr_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .rx_byte       (req_rx_byte),
      .end_of_packet (req_end_of_packet),
      .summary       (summary)
   );

   fsfr_verdict u_verdict (
      .summary        (summary),
      .first_address  (first_address_ff),
      .second_address (second_address_ff),
      .verdict        (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_end_of_packet) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_end_of_packet) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_status      = rsp_ff.status;
   assign rsp_sensor_index      = rsp_ff.sensor_index;
   assign rsp_fuel_level_tenths = rsp_ff.level;

   `FSFR_ASSERT_NEXT(a_last_byte_gives_result, take && req_end_of_packet, rsp_valid, "last byte without result")
   `FSFR_ASSERT_NOW(a_result_from_last_byte, $rose(rsp_valid), $past(take && req_end_of_packet), "result without last byte")
   `FSFR_ASSERT_NOW(a_reject_zeroes_fields, rsp_valid && (rsp_frame_status != STATUS_OK), (rsp_sensor_index == 1'b0) && (rsp_fuel_level_tenths == 16'd0), "rejected frame carries data")

endmodule
